// File: rtl/host_service_table_defines.svh
// Assertion macros shared by the checker of the host service table.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef HOST_SERVICE_TABLE_DEFINES_SVH
`define HOST_SERVICE_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hst_pkg.sv
// Package of the host service table: field widths, codes, shared types.
// No dependencies; every other .sv file under rtl refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package hst_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int PORT_W   = 16;
    localparam int PROTO_W  = 8;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int POL_W    = 4;
    localparam int MAXS_W   = 5;
    localparam int CNT_W    = 5;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Operation codes of an input transfer
    typedef enum logic [KIND_W-1:0] {
        KIND_UPDATE = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_UPDATED   = 3'd0,
        STAT_ADDED     = 3'd1,
        STAT_OVERFLOW  = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_CLEARED   = 3'd5
    } status_t;

    // Configuration register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_MAX_SERVICES  = 2'd0,
        REG_FRAG_POLICY   = 2'd1,
        REG_STREAM_POLICY = 2'd2
    } reg_idx_t;

    localparam logic [MAXS_W-1:0] MAX_SERVICES_RST = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_RESOLVE,
        ST_CLEAR
    } state_t;

    // One table entry: 41 bits
    typedef struct packed {
        logic [PORT_W-1:0]  port;
        logic [PROTO_W-1:0] proto;
        logic [ID_W-1:0]    id;
        logic               appid;
    } entry_t;

    typedef struct packed {
        kind_t  kind;
        entry_t ent;
    } op_t;

    // Broadcast from control to every cell
    typedef struct packed {
        logic   match;
        entry_t key;
    } cell_cmd_t;

    // Configuration seen by the control
    typedef struct packed {
        logic [MAXS_W-1:0] max_services;
        logic [POL_W-1:0]  frag_pol;
        logic [POL_W-1:0]  stream_pol;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/hst_if.sv
// Valid/ready channel interfaces of the host service table.
// Depends on hst_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hst_in_if;
    logic                         valid;
    logic                         ready;
    logic [hst_pkg::KIND_W-1:0]   kind;
    logic [hst_pkg::PORT_W-1:0]   port;
    logic [hst_pkg::PROTO_W-1:0]  ip_protocol;
    logic [hst_pkg::ID_W-1:0]     app_protocol_id;
    logic                         from_appid;

    modport source (output valid, kind, port, ip_protocol, app_protocol_id, from_appid,
                    input ready);
    modport sink   (input valid, kind, port, ip_protocol, app_protocol_id, from_appid,
                    output ready);
endinterface

interface hst_out_if;
    logic                          valid;
    logic                          ready;
    logic [hst_pkg::STATUS_W-1:0]  status;
    logic [hst_pkg::ID_W-1:0]      found_protocol_id;
    logic [hst_pkg::POL_W-1:0]     frag_policy_out;
    logic [hst_pkg::POL_W-1:0]     stream_policy_out;
    logic [hst_pkg::CNT_W-1:0]     entry_count;

    modport source (output valid, status, found_protocol_id, frag_policy_out,
                    stream_policy_out, entry_count, input ready);
    modport sink   (input valid, status, found_protocol_id, frag_policy_out,
                    stream_policy_out, entry_count, output ready);
endinterface

`default_nettype wire

// File: rtl/host_service_table.sv
// Top level of the host service table: APB registers, sequencer and a row
// of DEPTH table cells. Uses hst_pkg, hst_if, hst_cfg, hst_ctrl, hst_cell.
//
//  channel  role    handshake            payload
//  req      sink    valid/ready          kind, port, ip_protocol, app_protocol_id, from_appid
//  rsp      source  valid/ready          status, found_protocol_id, policies, entry_count
//  apb      slave   psel/penable/pready  paddr[3:0], pwdata, prdata (32 bits)
//
// Update and lookup go through accept, cell compare, first-match pick and resolve.
// Clear goes through accept and cell compare, then one shift of the cells per removed entry.
// Kind 3 is accepted and dropped with no result.
// No clearing pass after reset: the fill count alone marks live cells.
// A result waits in the output register; the next transfer is accepted meanwhile
// and its resolve step holds until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module host_service_table #(
    parameter int TABLE_DEPTH = hst_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    hst_in_if.sink                           req,
    hst_out_if.source                        rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hst_pkg::APB_AW-1:0]  paddr,
    input  wire logic [hst_pkg::APB_DW-1:0]  pwdata,
    output logic      [hst_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    hst_pkg::cfg_t      cfg;
    hst_pkg::cell_cmd_t cmd;
    hst_pkg::entry_t    ents [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_full;
    logic [TABLE_DEPTH-1:0] hit_port;
    logic [TABLE_DEPTH-1:0] rm;
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] load_vec;
    logic [TABLE_DEPTH-1:0] upd_vec;
    logic [TABLE_DEPTH-1:0] shift_vec;

    hst_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hst_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .cell_ent  (ents),
        .hit_full  (hit_full),
        .hit_port  (hit_port),
        .rm        (rm),
        .cmd       (cmd),
        .valid_vec (valid_vec),
        .load_vec  (load_vec),
        .upd_vec   (upd_vec),
        .shift_vec (shift_vec)
    );

    // Cell row; each cell takes its upper neighbor on a shift, the top one takes zero
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        hst_pkg::entry_t nbr_ent;
        logic            nbr_rm;

        if (i == TABLE_DEPTH - 1)
        begin : g_top
            assign nbr_ent = '0;
            assign nbr_rm  = 1'b0;
        end
        else
        begin : g_mid
            assign nbr_ent = ents[i+1];
            assign nbr_rm  = rm[i+1];
        end

        hst_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .valid    (valid_vec[i]),
            .load     (load_vec[i]),
            .upd      (upd_vec[i]),
            .shift    (shift_vec[i]),
            .nbr_ent  (nbr_ent),
            .nbr_rm   (nbr_rm),
            .ent      (ents[i]),
            .hit_full (hit_full[i]),
            .hit_port (hit_port[i]),
            .rm       (rm[i])
        );
    end

endmodule

`default_nettype wire

// File: rtl/hst_cell.sv
// One table cell: holds one entry, compares it against the broadcast key,
// and takes its upper neighbor's entry when the table closes up. Uses hst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hst_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hst_pkg::cell_cmd_t cmd,
    input  wire logic               valid,
    input  wire logic               load,
    input  wire logic               upd,
    input  wire logic               shift,
    input  wire hst_pkg::entry_t    nbr_ent,
    input  wire logic               nbr_rm,
    output hst_pkg::entry_t         ent,
    output logic                    hit_full,
    output logic                    hit_port,
    output logic                    rm
);

    hst_pkg::entry_t ent_reg, ent_next;
    logic hit_full_reg, hit_full_next;
    logic hit_port_reg, hit_port_next;
    logic rm_reg, rm_next;

    // Match flags and removal mark
    always_comb
    begin
        hit_full_next = hit_full_reg;
        hit_port_next = hit_port_reg;
        rm_next       = rm_reg;
        if (cmd.match)
        begin
            hit_port_next = valid && (ent_reg.port == cmd.key.port);
            hit_full_next = valid && (ent_reg.port == cmd.key.port)
                            && (ent_reg.proto == cmd.key.proto);
            rm_next       = valid && ent_reg.appid && (ent_reg.id != '0);
        end
        else if (shift)
        begin
            rm_next = nbr_rm;
        end
    end

    // Entry contents
    always_comb
    begin
        ent_next = ent_reg;
        priority if (shift)
        begin
            ent_next = nbr_ent;
        end
        else if (load)
        begin
            ent_next = cmd.key;
        end
        else if (upd)
        begin
            ent_next.id    = cmd.key.id;
            ent_next.appid = cmd.key.appid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_full_reg <= 1'b0;
            hit_port_reg <= 1'b0;
            rm_reg       <= 1'b0;
        end
        else
        begin
            hit_full_reg <= hit_full_next;
            hit_port_reg <= hit_port_next;
            rm_reg       <= rm_next;
        end
    end

    // Payload, no reset: read only below the fill count
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent      = ent_reg;
    assign hit_full = hit_full_reg;
    assign hit_port = hit_port_reg;
    assign rm       = rm_reg;

endmodule

`default_nettype wire

// File: rtl/hst_cfg.sv
// APB configuration registers: service limit, fragment and stream policy codes.
// Uses hst_pkg; pready is tied high.
`timescale 1ns / 1ps
`default_nettype none

module hst_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hst_pkg::APB_AW-1:0]    paddr,
    input  wire logic [hst_pkg::APB_DW-1:0]    pwdata,
    output logic      [hst_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    output hst_pkg::cfg_t                      cfg
);

    logic [hst_pkg::MAXS_W-1:0] max_reg, max_next;
    logic [hst_pkg::POL_W-1:0]  frag_reg, frag_next;
    logic [hst_pkg::POL_W-1:0]  stream_reg, stream_next;
    hst_pkg::reg_idx_t          idx;
    logic                       wr_en;

    assign idx    = hst_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes
    always_comb
    begin
        max_next    = max_reg;
        frag_next   = frag_reg;
        stream_next = stream_reg;
        if (wr_en)
        begin
            unique case (idx)
                hst_pkg::REG_MAX_SERVICES:  max_next    = pwdata[hst_pkg::MAXS_W-1:0];
                hst_pkg::REG_FRAG_POLICY:   frag_next   = pwdata[hst_pkg::POL_W-1:0];
                hst_pkg::REG_STREAM_POLICY: stream_next = pwdata[hst_pkg::POL_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= hst_pkg::MAX_SERVICES_RST;
            frag_reg   <= '0;
            stream_reg <= '0;
        end
        else
        begin
            max_reg    <= max_next;
            frag_reg   <= frag_next;
            stream_reg <= stream_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            hst_pkg::REG_MAX_SERVICES:  prdata = hst_pkg::APB_DW'(max_reg);
            hst_pkg::REG_FRAG_POLICY:   prdata = hst_pkg::APB_DW'(frag_reg);
            hst_pkg::REG_STREAM_POLICY: prdata = hst_pkg::APB_DW'(stream_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.max_services = max_reg;
    assign cfg.frag_pol     = frag_reg;
    assign cfg.stream_pol   = stream_reg;

endmodule

`default_nettype wire

// File: rtl/hst_ctrl.sv
// Sequencer of the host service table: latches an operation, picks the first
// matching cell, drives cell writes and close-up shifts, holds the fill count
// and the result register. Uses hst_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module hst_ctrl #(
    parameter int DEPTH = hst_pkg::TABLE_DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    hst_in_if.sink                  req,
    hst_out_if.source               rsp,
    input  wire hst_pkg::cfg_t      cfg,
    input  wire hst_pkg::entry_t    cell_ent [DEPTH],
    input  wire logic [DEPTH-1:0]   hit_full,
    input  wire logic [DEPTH-1:0]   hit_port,
    input  wire logic [DEPTH-1:0]   rm,
    output hst_pkg::cell_cmd_t      cmd,
    output logic [DEPTH-1:0]        valid_vec,
    output logic [DEPTH-1:0]        load_vec,
    output logic [DEPTH-1:0]        upd_vec,
    output logic [DEPTH-1:0]        shift_vec
);

    localparam int MW = (CW > hst_pkg::MAXS_W) ? CW : hst_pkg::MAXS_W;

    hst_pkg::state_t state_reg, state_next;
    hst_pkg::op_t    op_reg, op_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [DEPTH-1:0] first_reg, first_next;
    logic            any_reg, any_next;

    logic                         rsp_valid_reg, rsp_valid_next;
    logic [hst_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [hst_pkg::ID_W-1:0]     fid_reg, fid_next;
    logic [hst_pkg::POL_W-1:0]    fpol_reg, fpol_next;
    logic [hst_pkg::POL_W-1:0]    spol_reg, spol_next;
    logic [hst_pkg::CNT_W-1:0]    cnt_out_reg, cnt_out_next;

    logic                     accept;
    logic                     out_free;
    logic                     room;
    logic                     rsp_fire;
    logic [DEPTH-1:0]         hits;
    logic [DEPTH-1:0]         rm_first;
    logic [hst_pkg::ID_W-1:0] found_id;
    hst_pkg::status_t         res_status;
    logic [hst_pkg::ID_W-1:0] res_id;
    logic                     res_pol;

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign room     = (count_reg < CW'(DEPTH))
                      && (MW'(count_reg) < MW'(cfg.max_services));
    assign hits     = (op_reg.kind == hst_pkg::KIND_LOOKUP) ? hit_port : hit_full;
    assign rm_first = rm & (~rm + DEPTH'(1));

    // Id of the selected cell
    always_comb
    begin
        found_id = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            found_id = found_id | (cell_ent[i].id & {hst_pkg::ID_W{first_reg[i]}});
        end
    end

    // Cells below the fill count hold live entries
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = CW'(i) < count_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hst_pkg::ST_IDLE:
            begin
                if (accept && (hst_pkg::kind_t'(req.kind) != hst_pkg::KIND_NONE))
                begin
                    state_next = hst_pkg::ST_MATCH;
                end
            end
            hst_pkg::ST_MATCH:
            begin
                state_next = (op_reg.kind == hst_pkg::KIND_CLEAR) ? hst_pkg::ST_CLEAR
                                                                  : hst_pkg::ST_PICK;
            end
            hst_pkg::ST_PICK:
            begin
                state_next = hst_pkg::ST_RESOLVE;
            end
            hst_pkg::ST_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = hst_pkg::ST_IDLE;
                end
            end
            hst_pkg::ST_CLEAR:
            begin
                if (!(|rm) && out_free)
                begin
                    state_next = hst_pkg::ST_IDLE;
                end
            end
            default: state_next = hst_pkg::ST_IDLE;
        endcase
    end

    // Outputs: cell strobes, count update, result
    always_comb
    begin
        req.ready  = (state_reg == hst_pkg::ST_IDLE);
        cmd.match  = (state_reg == hst_pkg::ST_MATCH);
        cmd.key    = op_reg.ent;
        load_vec   = '0;
        upd_vec    = '0;
        shift_vec  = '0;
        count_next = count_reg;
        rsp_fire   = 1'b0;
        res_status = hst_pkg::STAT_UPDATED;
        res_id     = '0;
        res_pol    = 1'b0;
        unique case (state_reg)
            hst_pkg::ST_RESOLVE:
            begin
                if (out_free)
                begin
                    rsp_fire = 1'b1;
                    if (op_reg.kind == hst_pkg::KIND_LOOKUP)
                    begin
                        res_pol    = 1'b1;
                        res_status = any_reg ? hst_pkg::STAT_FOUND : hst_pkg::STAT_NOT_FOUND;
                        res_id     = found_id;
                    end
                    else if (any_reg)
                    begin
                        res_status = hst_pkg::STAT_UPDATED;
                        if (found_id != op_reg.ent.id)
                        begin
                            upd_vec = first_reg;
                        end
                    end
                    else if (room)
                    begin
                        res_status = hst_pkg::STAT_ADDED;
                        count_next = count_reg + CW'(1);
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            load_vec[i] = (count_reg == CW'(i));
                        end
                    end
                    else
                    begin
                        res_status = hst_pkg::STAT_OVERFLOW;
                    end
                end
            end
            hst_pkg::ST_CLEAR:
            begin
                // Drop the lowest marked entry; everything above moves down one
                if (|rm)
                begin
                    shift_vec  = ~(rm_first - DEPTH'(1));
                    count_next = count_reg - CW'(1);
                end
                else if (out_free)
                begin
                    rsp_fire   = 1'b1;
                    res_status = hst_pkg::STAT_CLEARED;
                end
            end
            default: ;
        endcase
    end

    // Operation latch and first-match pick
    always_comb
    begin
        op_next    = op_reg;
        first_next = first_reg;
        any_next   = any_reg;
        if (accept)
        begin
            op_next.kind      = hst_pkg::kind_t'(req.kind);
            op_next.ent.port  = req.port;
            op_next.ent.proto = req.ip_protocol;
            op_next.ent.id    = req.app_protocol_id;
            op_next.ent.appid = req.from_appid;
        end
        if (state_reg == hst_pkg::ST_PICK)
        begin
            first_next = hits & (~hits + DEPTH'(1));
            any_next   = |hits;
        end
    end

    // Result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        fid_next       = fid_reg;
        fpol_next      = fpol_reg;
        spol_next      = spol_reg;
        cnt_out_next   = cnt_out_reg;
        if (rsp_fire)
        begin
            rsp_valid_next = 1'b1;
            status_next    = res_status;
            fid_next       = res_id;
            fpol_next      = res_pol ? cfg.frag_pol : '0;
            spol_next      = res_pol ? cfg.stream_pol : '0;
            cnt_out_next   = hst_pkg::CNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hst_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        first_reg   <= first_next;
        any_reg     <= any_next;
        status_reg  <= status_next;
        fid_reg     <= fid_next;
        fpol_reg    <= fpol_next;
        spol_reg    <= spol_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.status            = status_reg;
    assign rsp.found_protocol_id = fid_reg;
    assign rsp.frag_policy_out   = fpol_reg;
    assign rsp.stream_policy_out = spol_reg;
    assign rsp.entry_count       = cnt_out_reg;

endmodule

`default_nettype wire

// File: rtl/hst_checker.sv
// Port-level checker of the host service table, bound to the top level.
// Uses hst_pkg codes and the macros of host_service_table_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "host_service_table_defines.svh"

module hst_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           req_valid,
    input wire logic                           req_ready,
    input wire logic [hst_pkg::KIND_W-1:0]     req_kind,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic [hst_pkg::STATUS_W-1:0]   rsp_status,
    input wire logic [hst_pkg::ID_W-1:0]       rsp_found_id,
    input wire logic [hst_pkg::POL_W-1:0]      rsp_frag,
    input wire logic [hst_pkg::POL_W-1:0]      rsp_stream
);

    // Stalled result stays and holds its status
    `HST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "result dropped or changed while stalled")

    // Only a found lookup carries an id
    `HST_ASSERT_NOW(a_id_zero, rsp_valid && (rsp_status != hst_pkg::STAT_FOUND), rsp_found_id == '0, "id set on a result other than found")

    // Policies are echoed on lookups only
    `HST_ASSERT_NOW(a_pol_zero, rsp_valid && (rsp_status != hst_pkg::STAT_FOUND) && (rsp_status != hst_pkg::STAT_NOT_FOUND), (rsp_frag == '0) && (rsp_stream == '0), "policy set on a non-lookup result")

    // A real operation keeps the input closed for its compare cycle
    `HST_ASSERT_NEXT(a_busy, req_valid && req_ready && (req_kind != hst_pkg::KIND_NONE), !req_ready, "input open right after an operation")

endmodule

bind host_service_table hst_checker u_hst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_kind     (req.kind),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_found_id (rsp.found_protocol_id),
    .rsp_frag     (rsp.frag_policy_out),
    .rsp_stream   (rsp.stream_policy_out)
);

`default_nettype wire

// File: dv/host_service_table_tb.sv
// Self-checking testbench of the host service table: directed and random
// update, lookup and clear transfers checked against an in-bench table model.
// Depends on hst_pkg, hst_if (hst_in_if, hst_out_if) and host_service_table.
`timescale 1ns / 1ps

module host_service_table_tb;

    localparam int TABLE_DEPTH    = hst_pkg::TABLE_DEPTH_DEF;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 325;

    localparam int PORT_W  = hst_pkg::PORT_W;
    localparam int PROTO_W = hst_pkg::PROTO_W;
    localparam int ID_W    = hst_pkg::ID_W;
    localparam int POL_W   = hst_pkg::POL_W;
    localparam int CNT_W   = hst_pkg::CNT_W;
    localparam int MAXS_W  = hst_pkg::MAXS_W;
    localparam int APB_AW  = hst_pkg::APB_AW;
    localparam int APB_DW  = hst_pkg::APB_DW;

    typedef struct {
        hst_pkg::kind_t     kind;
        logic [PORT_W-1:0]  port;
        logic [PROTO_W-1:0] proto;
        logic [ID_W-1:0]    id;
        logic               appid;
    } svc_request_t;

    typedef struct {
        hst_pkg::status_t   status;
        logic [ID_W-1:0]    id;
        logic [POL_W-1:0]   frag;
        logic [POL_W-1:0]   stream;
        logic [CNT_W-1:0]   count;
    } svc_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    hst_in_if  req_if ();
    hst_out_if rsp_if ();

    host_service_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Stimulus and expectation stores
    svc_request_t pending_requests[$];
    svc_result_t  expected_results[$];

    // Mirror of the block state and configuration
    hst_pkg::entry_t   svc_table [TABLE_DEPTH];
    int unsigned       svc_count;
    logic [MAXS_W-1:0] cfg_max_services;
    logic [POL_W-1:0]  cfg_frag_pol;
    logic [POL_W-1:0]  cfg_stream_pol;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    logic        hold_toggle    = 1'b0;
    logic        hold_seen;
    int unsigned hold_left;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;

    // Previous update, replayed now and then to hit the same-id case
    svc_request_t last_update;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Expected result of one accepted transfer; kind 3 gives none
    function automatic void predict_service(input svc_request_t rq);
        svc_result_t r;
        int unsigned limit;
        int unsigned keep;
        bit          hit;
        r.status = hst_pkg::STAT_UPDATED;
        r.id     = '0;
        r.frag   = '0;
        r.stream = '0;
        hit      = 1'b0;
        case (rq.kind)
            hst_pkg::KIND_UPDATE:
            begin
                limit = (cfg_max_services < TABLE_DEPTH) ? cfg_max_services : TABLE_DEPTH;
                for (int i = 0; i < svc_count; i++)
                begin
                    if (!hit && svc_table[i].port == rq.port && svc_table[i].proto == rq.proto)
                    begin
                        hit = 1'b1;
                        if (svc_table[i].id != rq.id)
                        begin
                            svc_table[i].id    = rq.id;
                            svc_table[i].appid = rq.appid;
                        end
                    end
                end
                if (hit)
                    r.status = hst_pkg::STAT_UPDATED;
                else if (svc_count < limit)
                begin
                    svc_table[svc_count] = '{port: rq.port, proto: rq.proto, id: rq.id,
                                             appid: rq.appid};
                    svc_count++;
                    r.status = hst_pkg::STAT_ADDED;
                end
                else
                    r.status = hst_pkg::STAT_OVERFLOW;
            end
            hst_pkg::KIND_LOOKUP:
            begin
                r.status = hst_pkg::STAT_NOT_FOUND;
                r.frag   = cfg_frag_pol;
                r.stream = cfg_stream_pol;
                for (int i = 0; i < svc_count; i++)
                begin
                    if (!hit && svc_table[i].port == rq.port)
                    begin
                        hit      = 1'b1;
                        r.status = hst_pkg::STAT_FOUND;
                        r.id     = svc_table[i].id;
                    end
                end
            end
            hst_pkg::KIND_CLEAR:
            begin
                // drop learned entries with a known id, close up the rest
                keep = 0;
                for (int i = 0; i < svc_count; i++)
                begin
                    if (!(svc_table[i].appid && svc_table[i].id != '0))
                    begin
                        svc_table[keep] = svc_table[i];
                        keep++;
                    end
                end
                svc_count = keep;
                r.status  = hst_pkg::STAT_CLEARED;
            end
            default:
                return;
        endcase
        r.count = svc_count[CNT_W-1:0];
        expected_results.push_back(r);
    endfunction

    function automatic void queue_request(input hst_pkg::kind_t k,
                                          input logic [PORT_W-1:0] p,
                                          input logic [PROTO_W-1:0] pr,
                                          input logic [ID_W-1:0] id, input logic ap);
        svc_request_t rq;
        rq.kind  = k;
        rq.port  = p;
        rq.proto = pr;
        rq.id    = id;
        rq.appid = ap;
        pending_requests.push_back(rq);
    endfunction

    // Random transfer: small pools of ports, protocols and ids so entries collide
    function automatic svc_request_t random_request();
        svc_request_t rq;
        int unsigned  pick;
        logic [PORT_W-1:0]  port_pool [8] = '{16'd0, 16'd1, 16'd53, 16'd80, 16'd443,
                                              16'h8000, 16'h7FFF, 16'hFFFF};
        logic [PROTO_W-1:0] proto_pool [4] = '{8'd6, 8'd17, 8'd0, 8'hFF};
        logic [ID_W-1:0]    id_pool [4] = '{16'd0, 16'd1, 16'h5555, 16'hFFFF};
        pick = $urandom_range(99);
        if (pick < 50)
            rq.kind = hst_pkg::KIND_UPDATE;
        else if (pick < 85)
            rq.kind = hst_pkg::KIND_LOOKUP;
        else if (pick < 95)
            rq.kind = hst_pkg::KIND_CLEAR;
        else
            rq.kind = hst_pkg::KIND_NONE;
        rq.port  = ($urandom_range(99) < 70) ? port_pool[$urandom_range(7)]
                                             : PORT_W'($urandom);
        rq.proto = ($urandom_range(99) < 70) ? proto_pool[$urandom_range(3)]
                                             : PROTO_W'($urandom);
        rq.id    = ($urandom_range(99) < 35) ? id_pool[$urandom_range(3)]
                                             : ID_W'($urandom);
        rq.appid = 1'($urandom_range(1));
        if (rq.kind == hst_pkg::KIND_UPDATE)
        begin
            if ($urandom_range(99) < 20)
            begin
                rq.port  = last_update.port;
                rq.proto = last_update.proto;
                rq.id    = last_update.id;
            end
            last_update = rq;
        end
        return rq;
    endfunction

    // APB write: setup then access; the register takes the data at the access edge
    task automatic write_reg(input hst_pkg::reg_idx_t idx, input logic [APB_DW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hst_pkg::REG_MAX_SERVICES:  cfg_max_services = value[MAXS_W-1:0];
            hst_pkg::REG_FRAG_POLICY:   cfg_frag_pol     = value[POL_W-1:0];
            hst_pkg::REG_STREAM_POLICY: cfg_stream_pol   = value[POL_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every queued transfer is done and every result is in
    task automatic wait_drained();
        while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                             input logic [MAXS_W-1:0] maxs, input logic [POL_W-1:0] fp,
                             input logic [POL_W-1:0] sp, input bit long_hold);
        write_reg(hst_pkg::REG_MAX_SERVICES, APB_DW'(maxs));
        write_reg(hst_pkg::REG_FRAG_POLICY, APB_DW'(fp));
        write_reg(hst_pkg::REG_STREAM_POLICY, APB_DW'(sp));
        src_idle_pct   <= src_pct;
        sink_stall_pct <= snk_pct;
        @(posedge clk);
        for (int i = 0; i < PHASE_ITEMS; i++)
            pending_requests.push_back(random_request());
        if (long_hold)
            hold_toggle <= ~hold_toggle;
        wait_drained();
    endtask

    // Input driver: predict on each accepted transfer, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid           <= 1'b0;
            req_if.kind            <= hst_pkg::KIND_NONE;
            req_if.port            <= '0;
            req_if.ip_protocol     <= '0;
            req_if.app_protocol_id <= '0;
            req_if.from_appid      <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                predict_service(pending_requests.pop_front());
            if (!(req_if.valid && !req_if.ready))
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    req_if.valid           <= 1'b1;
                    req_if.kind            <= pending_requests[0].kind;
                    req_if.port            <= pending_requests[0].port;
                    req_if.ip_protocol     <= pending_requests[0].proto;
                    req_if.app_protocol_id <= pending_requests[0].id;
                    req_if.from_appid      <= pending_requests[0].appid;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    task automatic check_result();
        svc_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("unexpected result, status", rsp_if.status, 0);
            return;
        end
        want = expected_results.pop_front();
        if (rsp_if.status != want.status)
            report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.found_protocol_id != want.id)
            report_mismatch("found_protocol_id", rsp_if.found_protocol_id, want.id);
        if (rsp_if.frag_policy_out != want.frag)
            report_mismatch("frag_policy_out", rsp_if.frag_policy_out, want.frag);
        if (rsp_if.stream_policy_out != want.stream)
            report_mismatch("stream_policy_out", rsp_if.stream_policy_out, want.stream);
        if (rsp_if.entry_count != want.count)
            report_mismatch("entry_count", rsp_if.entry_count, want.count);
    endtask

    // Result monitor with random stalls and an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            hold_seen    <= 1'b0;
            hold_left    <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
                check_result();
            if (hold_toggle != hold_seen)
            begin
                hold_seen    <= hold_toggle;
                hold_left    <= HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        cfg_max_services = hst_pkg::MAX_SERVICES_RST;
        cfg_frag_pol     = '0;
        cfg_stream_pol   = '0;
        svc_count        = 0;
        last_update      = '{hst_pkg::KIND_UPDATE, 16'd80, 8'd6, 16'd1, 1'b1};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset configuration
        queue_request(hst_pkg::KIND_LOOKUP, 16'h1234, 8'd0, 16'd0, 1'b0);      // empty table
        queue_request(hst_pkg::KIND_UPDATE, 16'h0000, 8'h00, 16'h0000, 1'b1);
        queue_request(hst_pkg::KIND_UPDATE, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
        queue_request(hst_pkg::KIND_UPDATE, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0);  // same id
        queue_request(hst_pkg::KIND_LOOKUP, 16'hFFFF, 8'h00, 16'h0000, 1'b0);
        queue_request(hst_pkg::KIND_LOOKUP, 16'h0000, 8'hFF, 16'hFFFF, 1'b1);  // id zero
        queue_request(hst_pkg::KIND_NONE, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);    // ignored
        queue_request(hst_pkg::KIND_UPDATE, 16'd80, 8'd6, 16'h0050, 1'b1);
        queue_request(hst_pkg::KIND_UPDATE, 16'd80, 8'd17, 16'h0051, 1'b0);
        queue_request(hst_pkg::KIND_LOOKUP, 16'd80, 8'd0, 16'd0, 1'b0);        // first wins
        queue_request(hst_pkg::KIND_CLEAR, 16'd0, 8'd0, 16'd0, 1'b0);
        queue_request(hst_pkg::KIND_LOOKUP, 16'hFFFF, 8'd0, 16'd0, 1'b0);
        queue_request(hst_pkg::KIND_LOOKUP, 16'd80, 8'd0, 16'd0, 1'b0);
        queue_request(hst_pkg::KIND_UPDATE, 16'h0000, 8'h00, 16'hAAAA, 1'b1);  // rewrite
        queue_request(hst_pkg::KIND_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
        wait_drained();

        // Zero limit: only matching updates succeed
        write_reg(hst_pkg::REG_MAX_SERVICES, 32'd0);
        queue_request(hst_pkg::KIND_UPDATE, 16'd1, 8'd1, 16'd1, 1'b0);
        queue_request(hst_pkg::KIND_UPDATE, 16'd80, 8'd17, 16'h0051, 1'b0);
        wait_drained();

        // Random phases over idling patterns and register settings
        run_phase(0, 0, 5'd31, 4'hF, 4'hF, 1'b0);
        run_phase(87, 0, 5'd16, 4'($urandom), 4'($urandom), 1'b0);
        run_phase(0, 87, 5'($urandom_range(16)), 4'($urandom), 4'($urandom), 1'b0);
        run_phase(34, 34, 5'd1, 4'h0, 4'hF, 1'b0);
        run_phase(0, 0, 5'd8, 4'hF, 4'h0, 1'b1);
        run_phase(34, 34, 5'($urandom_range(31)), 4'($urandom), 4'($urandom), 1'b0);

        if (expected_results.size() != 0)
            report_mismatch("results still expected", expected_results.size(), 0);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hst_pkg.sv
rtl/hst_if.sv
rtl/hst_cell.sv
rtl/hst_cfg.sv
rtl/hst_ctrl.sv
rtl/host_service_table.sv
rtl/hst_checker.sv
dv/host_service_table_tb.sv
